>>> sv/utp_pkg.sv
package utp_pkg;

    // one input word: a raw text byte and its end-of-text mark
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_word_t;

    // one result word: a page start, or the end-of-text summary
    typedef struct packed {
        logic [15:0] page_offset;
        logic [15:0] page_number;
        logic        is_summary;
        logic        run_end;
    } page_word_t;

    // outcome of decoding the character that starts at the scan pointer
    typedef struct packed {
        logic            place;      // a character (or replacement) is laid out
        logic            hold;       // unfinished sequence kept for the next byte
        logic            done;       // no bytes left after this step
        logic [20:0]     cp;
        logic [2:0]      next_i;
        logic [2:0]      after_rel;  // end offset of the character, relative to base
        logic [1:0]      hold_cnt;
        logic [2:0][7:0] tail;       // bytes from the scan pointer on
    } dec_t;

    // register indexes on the configuration port
    localparam logic [0:0] REG_UNITS_PER_ROW = 1'b0;
    localparam logic [0:0] REG_ROWS_PER_PAGE = 1'b1;

    localparam logic [7:0] UNITS_PER_ROW_RST = 8'd32;
    localparam logic [7:0] ROWS_PER_PAGE_RST = 8'd8;

    // utf-8 lead and continuation patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    localparam logic [20:0] CP_REPL      = 21'h00FFFD;
    localparam logic [20:0] CP_NEWLINE   = 21'h00000A;
    localparam logic [20:0] CP_ASCII_END = 21'h000080;
    localparam logic [20:0] CP_HALF_LO   = 21'h00FF61;
    localparam logic [20:0] CP_HALF_HI   = 21'h00FF9F;

    // ascii and halfwidth katakana take one unit
    function automatic logic is_half(input logic [20:0] cp);
        return (cp < CP_ASCII_END) || ((cp >= CP_HALF_LO) && (cp <= CP_HALF_HI));
    endfunction

    // punctuation that must not open a row
    function automatic logic is_no_start(input logic [20:0] cp);
        logic hit;
        case (cp) inside
            21'h003001, 21'h003002, 21'h00FF0C, 21'h00FF0E, 21'h00FF01,
            21'h00FF1F, 21'h00FF1A, 21'h00FF1B, 21'h00FF09, 21'h00300D,
            21'h00300F, 21'h003011, 21'h00300B, 21'h003009, 21'h002026,
            21'h002015, 21'h002014, 21'h0030FB, 21'h00FF5D, 21'h003015:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> sv/utp_decode.sv
module utp_decode
    import utp_pkg::*;
(
    input  logic [3:0][7:0] s,
    input  logic [1:0]      pos,
    input  logic [2:0]      count,
    input  logic            fin,
    output dec_t            dec
);

    logic [3:0][2:0] widx;
    logic [3:0][7:0] w;
    logic [2:0]      avail;
    logic [2:0]      need;
    logic [2:0]      adv;
    logic            ascii;
    logic            lead2;
    logic            lead3;
    logic            lead4;
    logic            multi;
    logic            short_seq;
    logic            c1;
    logic            c2;
    logic            c3;
    logic            cont_ok;
    logic [20:0]     cp_ok;

    // window of bytes from the lead on, zero past the buffer
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            widx[k] = {1'b0, pos} + 3'(k);
            w[k]    = widx[k][2] ? 8'h00 : s[widx[k][1:0]];
        end
    end

    assign avail = count - {1'b0, pos};
    assign ascii = ~w[0][7];
    assign lead2 = (w[0] & LEAD2_MASK) == LEAD2_CODE;
    assign lead3 = (w[0] & LEAD3_MASK) == LEAD3_CODE;
    assign lead4 = (w[0] & LEAD4_MASK) == LEAD4_CODE;
    assign multi = lead2 | lead3 | lead4;
    assign need  = lead2 ? 3'd2 : (lead3 ? 3'd3 : (lead4 ? 3'd4 : 3'd1));
    assign short_seq = multi && (need > avail);

    assign c1 = (w[1] & CONT_MASK) == CONT_CODE;
    assign c2 = (w[2] & CONT_MASK) == CONT_CODE;
    assign c3 = (w[3] & CONT_MASK) == CONT_CODE;
    assign cont_ok = c1 && ((need < 3'd3) || c2) && ((need < 3'd4) || c3);

    always_comb
    begin
        if (lead2)
            cp_ok = {10'd0, w[0][4:0], w[1][5:0]};
        else if (lead3)
            cp_ok = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
        else
            cp_ok = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
    end

    always_comb
    begin
        dec          = '0;
        dec.tail     = w[2:0];
        dec.hold_cnt = avail[1:0];
        adv          = 3'd1;
        if (short_seq)
        begin
            // cut off: one replacement at end of text, else keep the bytes
            dec.done   = 1'b1;
            dec.next_i = count;
            if (fin)
            begin
                dec.place     = 1'b1;
                dec.cp        = CP_REPL;
                dec.after_rel = count;
            end
            else
                dec.hold = 1'b1;
        end
        else
        begin
            dec.place = 1'b1;
            if (ascii)
                dec.cp = {13'd0, w[0]};
            else if (multi && cont_ok)
            begin
                dec.cp = cp_ok;
                adv    = need;
            end
            else
                dec.cp = CP_REPL;
            dec.next_i    = {1'b0, pos} + adv;
            dec.after_rel = dec.next_i;
            dec.done      = (dec.next_i == count);
        end
    end

endmodule

>>> sv/utf8_text_paginator.sv
// channel   direction  word          handshake
// text      in         text_word_t   text_valid / text_stall
// page      out        page_word_t   page_valid / page_stall
// config    in         8-bit data    cfg_wr_en / cfg_index
//
// one byte per cycle while text_stall is low; the scanner lays out one character
// per cycle unless page_stall backs up, so a malformed sequence that replays held
// bytes stalls text for each extra character, a page-opening last byte for the summary
// a word waits in the pending register until the next one (or the end of its
// byte) settles run_end, then moves to the output register
// rst_n clears the text state, the counters and the registers to 32 units and 8 rows
// page_stall backs up through the pending register into text_stall
module utf8_text_paginator
    import utp_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  text_word_t text_word,
    output logic       page_valid,
    input  logic       page_stall,
    output page_word_t page_word,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int OB = OFFSET_BITS;

    function automatic logic [OB-1:0] sat_off(input logic [OB:0] v);
        return v[OB] ? {OB{1'b1}} : v[OB-1:0];
    endfunction

    // configuration
    logic [7:0] upr_reg;
    logic [7:0] rpp_reg;

    // input register
    logic       iv_reg;
    text_word_t in_reg;

    // scanner: byte buffer of the current step and its pointer
    logic            act_reg, act_next;
    logic            sum_reg, sum_next;
    logic [3:0][7:0] s_reg, s_next;
    logic [2:0]      n_reg, n_next;
    logic [1:0]      i_reg, i_next;
    logic [OB-1:0]   base_reg, base_next;
    logic            fin_reg, fin_next;
    logic [OB-1:0]   len_reg, len_next;

    // text state
    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      hc_reg, hc_next;
    logic [OB-1:0]   seq_start_reg, seq_start_next;
    logic [OB-1:0]   pos_reg, pos_next;
    logic [7:0]      ru_reg, ru_next;
    logic [7:0]      ri_reg, ri_next;
    logic [15:0]     pt_reg, pt_next;

    // result side
    logic       pend_v_reg;
    logic       pend_last_reg;
    page_word_t pend_reg;
    logic       out_v_reg;
    page_word_t out_reg;

    // step source
    logic [3:0][7:0] src_s;
    logic [2:0]      src_n;
    logic [1:0]      src_i;
    logic [OB-1:0]   src_base;
    logic            src_fin;
    logic [OB-1:0]   src_len;
    logic [OB-1:0]   pos_sat;
    dec_t            dec;

    // layout
    logic [7:0]    width_eff;
    logic [7:0]    rows_eff;
    logic [1:0]    units;
    logic [OB-1:0] before_off;
    logic [OB-1:0] after_off;
    logic [OB-1:0] brk_off;
    logic          brk;
    logic [7:0]    ru_place;
    logic [7:0]    ri_inc;
    logic [7:0]    ri_place;
    logic [15:0]   pt_place;
    logic          gen_page;

    // flow control
    logic       out_free;
    logic       scan_go;
    logic       step;
    logic       take;
    logic       gen_valid;
    page_word_t gen_word;
    logic       byte_done;
    logic       push;
    logic       run_end_push;

    assign out_free   = !out_v_reg || !page_stall;
    assign scan_go    = !pend_v_reg || out_free;
    assign step       = scan_go && (act_reg || iv_reg);
    assign take       = step && !act_reg;
    assign text_stall = iv_reg && !take;

    assign page_valid = out_v_reg;
    assign page_word  = out_reg;

    // a fresh byte is appended behind the held bytes of an open sequence
    assign pos_sat = sat_off({1'b0, pos_reg} + {{OB{1'b0}}, 1'b1});

    always_comb
    begin
        if (act_reg)
        begin
            src_s    = s_reg;
            src_n    = n_reg;
            src_i    = i_reg;
            src_base = base_reg;
            src_fin  = fin_reg;
            src_len  = len_reg;
        end
        else
        begin
            src_s[0] = (hc_reg == 2'd0) ? in_reg.text_byte : held_reg[0];
            src_s[1] = (hc_reg == 2'd1) ? in_reg.text_byte :
                       ((hc_reg > 2'd1) ? held_reg[1] : 8'h00);
            src_s[2] = (hc_reg == 2'd2) ? in_reg.text_byte :
                       ((hc_reg > 2'd2) ? held_reg[2] : 8'h00);
            src_s[3] = (hc_reg == 2'd3) ? in_reg.text_byte : 8'h00;
            src_n    = {1'b0, hc_reg} + 3'd1;
            src_i    = 2'd0;
            src_base = (hc_reg != 2'd0) ? seq_start_reg : pos_reg;
            src_fin  = in_reg.final_byte;
            src_len  = pos_sat;
        end
    end

    utp_decode u_decode (
        .s     (src_s),
        .pos   (src_i),
        .count (src_n),
        .fin   (src_fin),
        .dec   (dec)
    );

    // greedy wrap of one character
    assign width_eff  = (upr_reg < 8'd2) ? 8'd2 : upr_reg;
    assign rows_eff   = (rpp_reg == 8'd0) ? 8'd1 : rpp_reg;
    assign units      = is_half(dec.cp) ? 2'd1 : 2'd2;
    assign before_off = sat_off({1'b0, src_base} + (OB+1)'(src_i));
    assign after_off  = sat_off({1'b0, src_base} + (OB+1)'(dec.after_rel));
    assign ri_inc     = ri_reg + 8'd1;

    always_comb
    begin
        brk      = 1'b0;
        brk_off  = after_off;
        ru_place = ru_reg + 8'(units);
        if (dec.cp == CP_NEWLINE)
        begin
            brk      = 1'b1;
            ru_place = 8'd0;
        end
        else if ((({1'b0, ru_reg} + 9'(units)) > {1'b0, width_eff}) && (ru_reg != 8'd0))
        begin
            brk = 1'b1;
            if (is_no_start(dec.cp))
                ru_place = 8'd0;            // hangs on this row, break after it
            else
            begin
                ru_place = 8'(units);       // moves down, break before it
                brk_off  = before_off;
            end
        end

        ri_place = ri_reg;
        pt_place = pt_reg;
        gen_page = 1'b0;
        if (brk)
        begin
            if (ri_inc >= rows_eff)
            begin
                ri_place = 8'd0;
                pt_place = (pt_reg != 16'hFFFF) ? pt_reg + 16'd1 : pt_reg;
                gen_page = 1'b1;
            end
            else
                ri_place = ri_inc;
        end
    end

    // sequencer: one character or the summary per step
    always_comb
    begin
        act_next       = act_reg;
        sum_next       = sum_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        base_next      = base_reg;
        fin_next       = fin_reg;
        len_next       = len_reg;
        held_next      = held_reg;
        hc_next        = hc_reg;
        seq_start_next = seq_start_reg;
        pos_next       = pos_reg;
        ru_next        = ru_reg;
        ri_next        = ri_reg;
        pt_next        = pt_reg;
        gen_valid      = 1'b0;
        gen_word       = '0;
        byte_done      = 1'b0;

        if (step)
        begin
            s_next    = src_s;
            n_next    = src_n;
            base_next = src_base;
            fin_next  = src_fin;
            len_next  = src_len;
            i_next    = dec.next_i[1:0];
            if (take)
            begin
                hc_next  = 2'd0;
                pos_next = src_fin ? '0 : pos_sat;
            end

            if (act_reg && sum_reg)
            begin
                // summary after a last character that opened a page
                gen_valid  = 1'b1;
                gen_word   = '{page_offset: 16'(len_reg), page_number: pt_reg,
                               is_summary: 1'b1, run_end: 1'b0};
                byte_done  = 1'b1;
                act_next   = 1'b0;
                sum_next   = 1'b0;
                ru_next    = 8'd0;
                ri_next    = 8'd0;
                pt_next    = 16'd1;
                pos_next   = '0;
            end
            else
            begin
                sum_next = 1'b0;
                if (dec.hold)
                begin
                    held_next      = dec.tail;
                    hc_next        = dec.hold_cnt;
                    seq_start_next = before_off;
                end
                if (dec.place)
                begin
                    ru_next = ru_place;
                    ri_next = ri_place;
                    pt_next = pt_place;
                    if (gen_page)
                    begin
                        gen_valid = 1'b1;
                        gen_word  = '{page_offset: 16'(brk_off), page_number: pt_place,
                                      is_summary: 1'b0, run_end: 1'b0};
                    end
                end
                if (!dec.done)
                    act_next = 1'b1;
                else if (!src_fin)
                begin
                    act_next  = 1'b0;
                    byte_done = 1'b1;
                end
                else if (gen_page)
                begin
                    act_next = 1'b1;
                    sum_next = 1'b1;
                end
                else
                begin
                    // no page word this step, so the summary goes out at once
                    gen_valid  = 1'b1;
                    gen_word   = '{page_offset: 16'(src_len), page_number: pt_reg,
                                   is_summary: 1'b1, run_end: 1'b0};
                    byte_done  = 1'b1;
                    act_next   = 1'b0;
                    ru_next    = 8'd0;
                    ri_next    = 8'd0;
                    pt_next    = 16'd1;
                    pos_next   = '0;
                    hc_next    = 2'd0;
                end
            end
        end
    end

    // pending word leaves once its successor or the end of its byte is known
    assign push = pend_v_reg && out_free &&
                  (pend_last_reg || (step && (gen_valid || byte_done)));
    assign run_end_push = pend_last_reg || !(step && gen_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upr_reg       <= UNITS_PER_ROW_RST;
            rpp_reg       <= ROWS_PER_PAGE_RST;
            iv_reg        <= 1'b0;
            act_reg       <= 1'b0;
            sum_reg       <= 1'b0;
            hc_reg        <= 2'd0;
            seq_start_reg <= '0;
            pos_reg       <= '0;
            ru_reg        <= 8'd0;
            ri_reg        <= 8'd0;
            pt_reg        <= 16'd1;
            pend_v_reg    <= 1'b0;
            pend_last_reg <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_UNITS_PER_ROW: upr_reg <= cfg_data;
                    REG_ROWS_PER_PAGE: rpp_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (text_valid && !text_stall)
                iv_reg <= 1'b1;
            else if (take)
                iv_reg <= 1'b0;

            act_reg       <= act_next;
            sum_reg       <= sum_next;
            hc_reg        <= hc_next;
            seq_start_reg <= seq_start_next;
            pos_reg       <= pos_next;
            ru_reg        <= ru_next;
            ri_reg        <= ri_next;
            pt_reg        <= pt_next;

            if (step && gen_valid)
            begin
                pend_v_reg    <= 1'b1;
                pend_last_reg <= byte_done;
            end
            else if (push)
                pend_v_reg <= 1'b0;

            if (push)
                out_v_reg <= 1'b1;
            else if (!page_stall)
                out_v_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
            in_reg <= text_word;
        s_reg    <= s_next;
        n_reg    <= n_next;
        i_reg    <= i_next;
        base_reg <= base_next;
        fin_reg  <= fin_next;
        len_reg  <= len_next;
        held_reg <= held_next;
        if (step && gen_valid)
            pend_reg <= gen_word;
        if (push)
            out_reg <= '{page_offset: pend_reg.page_offset,
                         page_number: pend_reg.page_number,
                         is_summary:  pend_reg.is_summary,
                         run_end:     run_end_push};
    end

    // the summary always closes the run of its byte
    a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        page_valid && page_word.is_summary |-> page_word.run_end)
        else $error("summary word without run_end");

    // bytes are held only once a byte's scan has finished
    a_no_hold_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> hc_reg == 2'd0)
        else $error("held bytes during a replay");

    // replay pointer stays inside the buffer
    a_pointer_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg && !sum_reg |-> {1'b0, i_reg} < n_reg)
        else $error("scan pointer past buffer end");

    // an open pending word means its byte is still being scanned
    a_pending_open: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg && !pend_last_reg |-> act_reg)
        else $error("pending word left without a closing step");

    a_page_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pt_reg != 16'd0)
        else $error("page count reached zero");

endmodule

>>> bench/tb_utf8_text_paginator.sv
module tb_utf8_text_paginator;
    import utp_pkg::*;

    // run-time bounds
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 12;      // covers replay, summary and both output stages
    localparam int OFFSET_TOP      = 65535;   // offsets, length and page count saturate here
    localparam int PHASE_BYTES     = 6;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_LINE_FEED   = 21'h00000A;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_stall;
    text_word_t text_word;
    logic       page_valid;
    logic       page_stall;
    page_word_t page_word;
    logic       cfg_wr_en;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    // ------------------------------------------------------------------
    // page predictor and result book
    // ------------------------------------------------------------------
    class page_scoreboard;
        page_word_t  pages_due[$];    // page words still to arrive, oldest first
        page_word_t  byte_pages[$];   // page words caused by the byte in hand
        int          errors;
        logic [7:0]  units_per_row;
        logic [7:0]  rows_per_page;
        logic [7:0]  held_bytes [3];
        int          held_count;
        int          byte_pos;
        int          seq_start;
        int          row_units;
        logic [7:0]  row_index;
        logic [15:0] page_total;

        function new();
            units_per_row = UNITS_PER_ROW_RST;
            rows_per_page = ROWS_PER_PAGE_RST;
            errors        = 0;
            clear_text();
        endfunction

        // punctuation that may not open a row
        static function logic [20:0] mark_of(int idx);
            logic [20:0] cp;
            case (idx)
                0:  cp = 21'h3001;
                1:  cp = 21'h3002;
                2:  cp = 21'hFF0C;
                3:  cp = 21'hFF0E;
                4:  cp = 21'hFF01;
                5:  cp = 21'hFF1F;
                6:  cp = 21'hFF1A;
                7:  cp = 21'hFF1B;
                8:  cp = 21'hFF09;
                9:  cp = 21'h300D;
                10: cp = 21'h300F;
                11: cp = 21'h3011;
                12: cp = 21'h300B;
                13: cp = 21'h3009;
                14: cp = 21'h2026;
                15: cp = 21'h2015;
                16: cp = 21'h2014;
                17: cp = 21'h30FB;
                18: cp = 21'hFF5D;
                default: cp = 21'h3015;
            endcase
            return cp;
        endfunction

        function bit hangs_at_row_end(logic [20:0] cp);
            for (int k = 0; k < 20; k++)
                if (mark_of(k) == cp)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void clear_text();
            foreach (held_bytes[k])
                held_bytes[k] = '0;
            held_count = 0;
            byte_pos   = 0;
            seq_start  = 0;
            row_units  = 0;
            row_index  = '0;
            page_total = 16'd1;
        endfunction

        function void write_reg(logic [0:0] idx, logic [7:0] value);
            if (idx == REG_UNITS_PER_ROW)
                units_per_row = value;
            else
                rows_per_page = value;
        endfunction

        function int clip_offset(int v);
            return (v > OFFSET_TOP) ? OFFSET_TOP : v;
        endfunction

        function void add_page(int off, logic [15:0] number, logic summary);
            page_word_t w;
            w.page_offset = 16'(clip_offset(off));
            w.page_number = number;
            w.is_summary  = summary;
            w.run_end     = 1'b0;
            byte_pages.push_back(w);
        endfunction

        function void break_row(int off);
            logic [7:0] rows;
            rows      = (rows_per_page < 8'd1) ? 8'd1 : rows_per_page;
            row_index = row_index + 8'd1;
            if (row_index >= rows) begin
                row_index = '0;
                if (page_total != 16'hFFFF)
                    page_total = page_total + 16'd1;
                add_page(off, page_total, 1'b0);
            end
        endfunction

        // greedy placement of one character spanning byte offsets start..stop
        function void lay_out(logic [20:0] cp, int start, int stop);
            int width;
            int units;
            width = (units_per_row < 8'd2) ? 2 : int'(units_per_row);
            units = ((cp < 21'h80) || (cp >= 21'hFF61 && cp <= 21'hFF9F)) ? 1 : 2;
            if (cp == CP_LINE_FEED) begin
                row_units = 0;
                break_row(stop);
            end
            else if (row_units + units > width && row_units > 0) begin
                if (hangs_at_row_end(cp)) begin
                    row_units = 0;
                    break_row(stop);
                end
                else begin
                    row_units = units;
                    break_row(start);
                end
            end
            else
                row_units = row_units + units;
        endfunction

        // decode one accepted byte together with any held lead bytes
        function void note_text(text_word_t w);
            logic [7:0]  seq [4];
            logic [20:0] cp;
            page_word_t  last;
            int          n;
            int          i;
            int          len;
            int          base;
            bit          bad;
            n = 0;
            i = 0;
            for (int k = 0; k < held_count; k++) begin
                seq[n] = held_bytes[k];
                n++;
            end
            seq[n] = w.text_byte;
            n++;
            base = (held_count != 0) ? seq_start : byte_pos;
            held_count = 0;
            byte_pages.delete();
            while (i < n) begin
                cp  = '0;
                len = 0;
                if (seq[i] < 8'h80)
                    len = 1;
                else if ((seq[i] & 8'hE0) == 8'hC0) begin
                    cp  = 21'(seq[i] & 8'h1F);
                    len = 2;
                end
                else if ((seq[i] & 8'hF0) == 8'hE0) begin
                    cp  = 21'(seq[i] & 8'h0F);
                    len = 3;
                end
                else if ((seq[i] & 8'hF8) == 8'hF0) begin
                    cp  = 21'(seq[i] & 8'h07);
                    len = 4;
                end
                if (len == 1) begin
                    lay_out(21'(seq[i]), base + i, base + i + 1);
                    i++;
                end
                else if (len == 0) begin
                    // bad lead byte
                    lay_out(CP_REPLACEMENT, base + i, base + i + 1);
                    i++;
                end
                else if (i + len > n) begin
                    if (w.final_byte)
                        // cut off by the end of the text: one replacement for all of it
                        lay_out(CP_REPLACEMENT, base + i, base + n);
                    else begin
                        held_count = n - i;
                        for (int k = 0; k < held_count; k++)
                            held_bytes[k] = seq[i + k];
                        seq_start = clip_offset(base + i);
                    end
                    i = n;
                end
                else begin
                    bad = 1'b0;
                    for (int k = 1; k < len; k++) begin
                        if ((seq[i + k] & 8'hC0) != 8'h80)
                            bad = 1'b1;
                        else if (!bad)
                            cp = {cp[14:0], seq[i + k][5:0]};
                    end
                    if (bad) begin
                        // replace the lead alone, rescan from the byte after it
                        lay_out(CP_REPLACEMENT, base + i, base + i + 1);
                        i++;
                    end
                    else begin
                        lay_out(cp, base + i, base + i + len);
                        i += len;
                    end
                end
            end
            byte_pos = clip_offset(byte_pos + 1);
            if (w.final_byte) begin
                add_page(byte_pos, page_total, 1'b1);
                clear_text();
            end
            if (byte_pages.size() > 0) begin
                last = byte_pages.pop_back();
                last.run_end = 1'b1;
                byte_pages.push_back(last);
            end
            foreach (byte_pages[k])
                pages_due.push_back(byte_pages[k]);
        endfunction

        function void check_page(page_word_t got);
            page_word_t want;
            if (pages_due.size() == 0) begin
                $error("page word with nothing expected: offset %0d, page %0d",
                       got.page_offset, got.page_number);
                errors++;
                return;
            end
            want = pages_due.pop_front();
            if (got.page_offset !== want.page_offset) begin
                $error("page_offset: expected %0d, got %0d", want.page_offset, got.page_offset);
                errors++;
            end
            if (got.page_number !== want.page_number) begin
                $error("page_number: expected %0d, got %0d", want.page_number, got.page_number);
                errors++;
            end
            if (got.is_summary !== want.is_summary) begin
                $error("is_summary: expected %0b, got %0b", want.is_summary, got.is_summary);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
                errors++;
            end
        endfunction

        function int pending();
            return pages_due.size();
        endfunction
    endclass

    page_scoreboard book;
    bit             calm;          // both sides run without idling while set
    logic [7:0]     text_q[$];     // bytes of the text being built
    int             bytes_sent;
    int             cycles;
    int             stall_left;

    // opening text: zero byte, newline, top ascii, two-, three- and four-byte
    // characters, a hanging full stop, halfwidth katakana, bad leads, a bad
    // continuation, a lenient F7 lead and a sequence cut off by the end
    logic [7:0] opening [25] = '{
        8'h00, 8'h0A, 8'h7F, 8'hC3, 8'hA9, 8'hE3, 8'h80, 8'h82, 8'hEF, 8'hBD,
        8'hB1, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hE3, 8'h41, 8'hF7,
        8'hBF, 8'hBF, 8'hBF, 8'hE3, 8'h81
    };

    utf8_text_paginator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_word  (text_word),
        .page_valid (page_valid),
        .page_stall (page_stall),
        .page_word  (page_word),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // page side: take a word, then hold stall for a random stretch
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (page_valid && !page_stall) begin
                book.check_page(page_word);
                stall_left = calm ? 0 : $urandom_range(0, 13);
            end
            else if (stall_left > 0)
                stall_left--;
            page_stall <= (stall_left != 0);
        end
    end

    // one text word; gap cycles with valid low first, then hold until taken
    task automatic send_byte(logic [7:0] b, logic fin);
        text_word_t w;
        int         gap;
        w.text_byte  = b;
        w.final_byte = fin;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_word  <= w;
        do @(posedge clk); while (text_stall);
        book.note_text(w);
        bytes_sent++;
    endtask

    task automatic send_text(bit finish);
        for (int k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], finish && (k == text_q.size() - 1));
        text_q.delete();
    endtask

    // encode cp in exactly len bytes, so short values give overlong forms
    function automatic void push_char(logic [20:0] cp, int len);
        case (len)
            1: text_q.push_back(cp[7:0]);
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // mostly well-formed characters, with some stray bytes and broken sequences
    task automatic random_text(int chars, bit finish);
        logic [7:0] lead;
        for (int k = 0; k < chars; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: push_char(21'($urandom_range(32, 126)), 1);
                6:                push_char(CP_LINE_FEED, 1);
                7:                push_char(21'($urandom_range(0, 127)), 1);
                8, 9:             push_char(21'($urandom_range(21'hFF61, 21'hFF9F)), 3);
                10, 11:           push_char(page_scoreboard::mark_of($urandom_range(0, 19)), 3);
                12, 13, 14:       push_char(21'($urandom_range(21'h3040, 21'h9FFF)), 3);
                15:               push_char(21'($urandom_range(0, 21'h7FF)), 2);
                16:               push_char(21'($urandom_range(0, 21'hFFFF)), 3);
                17:               push_char(21'($urandom_range(0, 21'h1FFFFF)), 4);
                18:               text_q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    // lead byte followed by something that is not a continuation
                    text_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                    text_q.push_back(8'($urandom_range(0, 8'h7F)));
                end
            endcase
        end
        if (finish && $urandom_range(0, 4) == 0) begin
            // text ends part way through a sequence
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            text_q.push_back(lead);
            if (lead >= 8'hE0)
                text_q.push_back(8'h80 | 8'($urandom_range(0, 8'h3F)));
        end
        if (text_q.size() == 0)
            text_q.push_back(8'h20);
        send_text(finish);
    endtask

    // quiet the text side and wait until every page word has come back
    task automatic settle();
        text_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [0:0] idx, logic [7:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.write_reg(idx, value);
    endtask

    task automatic run_phase(logic [7:0] units, logic [7:0] rows, bit quiet);
        int target;
        set_reg(REG_UNITS_PER_ROW, units);
        set_reg(REG_ROWS_PER_PAGE, rows);
        calm   = quiet;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target)
            random_text($urandom_range(2, 12), $urandom_range(0, 4) != 0);
    endtask

    initial
    begin
        book       = new();
        calm       = 1'b0;
        bytes_sent = 0;
        cycles     = 0;
        stall_left = 0;
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_word  = '0;
        page_stall = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_UNITS_PER_ROW;
        cfg_data   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few bytes on the reset settings first
        random_text(6, 1'b1);

        // narrowest rows, one row per page: nearly every character opens a page
        set_reg(REG_UNITS_PER_ROW, 8'd2);
        set_reg(REG_ROWS_PER_PAGE, 8'd1);
        foreach (opening[k])
            send_byte(opening[k], k == 24);

        // widest rows and tallest pages: little but summaries comes out
        run_phase(8'd255, 8'd255, 1'b0);
        run_phase(8'd2, 8'd1, 1'b1);
        run_phase(8'd6, 8'd3, 1'b0);
        run_phase(8'd40, 8'd7, 1'b0);
        // leave a wide row and a deep row index open, then shrink both under it
        random_text(16, 1'b0);
        run_phase(8'd3, 8'd1, 1'b0);
        run_phase(8'($urandom_range(2, 12)), 8'($urandom_range(1, 4)), 1'b0);
        run_phase(8'($urandom_range(2, 20)), 8'($urandom_range(1, 3)), 1'b1);
        run_phase(8'($urandom_range(2, 255)), 8'($urandom_range(1, 255)), 1'b0);
        run_phase(8'd4, 8'd2, 1'b0);

        // a short idling tail that ends the text, on the settings of the last phase
        calm = 1'b0;
        random_text(10, 1'b1);

        settle();
        if (book.errors == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/utp_pkg.sv
sv/utp_decode.sv
sv/utf8_text_paginator.sv
bench/tb_utf8_text_paginator.sv
